### rtl/assert_macros.svh
// shared assertion macros for the fault protection block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the rising clock edge, off during reset
`define DFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define DFP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dfp_pkg.sv
package dfp_pkg;

   localparam int unsigned LEVEL_W = 16;
   localparam int unsigned COUNT_W = 24;
   localparam int unsigned CSR_INDEX_W = 2;

   // action codes
   localparam logic [1:0] ACTION_TICK  = 2'd0;
   localparam logic [1:0] ACTION_FEED  = 2'd1;
   localparam logic [1:0] ACTION_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERCURRENT_LEVEL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERVOLTAGE_LEVEL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNDERVOLTAGE_LEVEL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WATCHDOG_LIMIT     = 2'd3;

   // register reset values
   localparam logic [LEVEL_W-1:0] OVERCURRENT_RESET  = 16'd32768;
   localparam logic [LEVEL_W-1:0] OVERVOLTAGE_RESET  = 16'd65535;
   localparam logic [LEVEL_W-1:0] UNDERVOLTAGE_RESET = 16'd0;
   localparam logic [COUNT_W-1:0] WATCHDOG_RESET     = 24'd1000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [LEVEL_W-1:0]  current_a;
      logic signed [LEVEL_W-1:0]  current_b;
      logic signed [LEVEL_W-1:0]  current_c;
      logic [LEVEL_W-1:0]         link_voltage;
      logic                       operator_enable;
      logic                       calibrated;
   } dfp_req_type;

   typedef struct packed {
      logic gate_ok;
      logic overcurrent_tripped;
      logic overvoltage_tripped;
      logic undervoltage_now;
      logic watchdog_expired;
      logic calibration_flag;
      logic enabled_flag;
   } dfp_rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] overcurrent_level;
      logic [LEVEL_W-1:0] overvoltage_level;
      logic [LEVEL_W-1:0] undervoltage_level;
      logic [COUNT_W-1:0] watchdog_limit;
   } dfp_cfg_type;

   typedef struct packed {
      logic               oc_latch;
      logic               ov_latch;
      logic               uv_flag;
      logic               wdt_flag;
      logic               calib_flag;
      logic               enable_flag;
      logic [COUNT_W-1:0] wdt_count;
   } dfp_state_type;

endpackage

### rtl/dfp_req_if.sv
interface dfp_req_if;
   logic                valid;
   logic                ready;
   dfp_pkg::dfp_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/dfp_rsp_if.sv
interface dfp_rsp_if;
   logic                valid;
   logic                ready;
   dfp_pkg::dfp_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/dfp_fault_core.sv
// next protection state for one transaction
module dfp_fault_core (
   input  dfp_pkg::dfp_state_type state_cur,
   input  dfp_pkg::dfp_cfg_type   cfg,
   input  dfp_pkg::dfp_req_type   item,
   output dfp_pkg::dfp_state_type state_next
);

   logic [dfp_pkg::LEVEL_W:0]   mag_a;
   logic [dfp_pkg::LEVEL_W:0]   mag_b;
   logic [dfp_pkg::LEVEL_W:0]   mag_c;
   logic [dfp_pkg::LEVEL_W:0]   oc_level_ext;
   logic                        oc_hit;
   logic                        ov_hit;
   logic                        uv_hit;
   logic [dfp_pkg::COUNT_W-1:0] count_inc;
   logic                        oc_tick;
   logic                        ov_tick;
   logic                        wdt_tick;

   // magnitude of a two's complement sample, one bit wider so -32768 fits
   function automatic logic [dfp_pkg::LEVEL_W:0] magnitude (
      input logic [dfp_pkg::LEVEL_W-1:0] raw
   );
      logic [dfp_pkg::LEVEL_W:0] ext;
      ext = {1'b0, raw};
      if (raw[dfp_pkg::LEVEL_W-1]) begin
         return (1'b1 << dfp_pkg::LEVEL_W) - ext;
      end
      return ext;
   endfunction

   always_comb begin
      mag_a        = magnitude($unsigned(item.current_a));
      mag_b        = magnitude($unsigned(item.current_b));
      mag_c        = magnitude($unsigned(item.current_c));
      oc_level_ext = {1'b0, cfg.overcurrent_level};
      oc_hit       = (mag_a > oc_level_ext) || (mag_b > oc_level_ext) ||
                     (mag_c > oc_level_ext);
      ov_hit       = item.link_voltage > cfg.overvoltage_level;
      uv_hit       = item.link_voltage < cfg.undervoltage_level;
      // saturating tick count
      count_inc    = (state_cur.wdt_count == dfp_pkg::COUNT_MAX) ?
                     state_cur.wdt_count : state_cur.wdt_count + 1'b1;
      oc_tick      = state_cur.oc_latch || oc_hit;
      ov_tick      = state_cur.ov_latch || ov_hit;
      wdt_tick     = state_cur.wdt_flag || (count_inc > cfg.watchdog_limit);

      state_next = state_cur;
      case (item.action)
         dfp_pkg::ACTION_TICK: begin
            state_next.oc_latch    = oc_tick;
            state_next.ov_latch    = ov_tick;
            state_next.uv_flag     = uv_hit;
            state_next.wdt_count   = count_inc;
            state_next.wdt_flag    = wdt_tick;
            state_next.calib_flag  = item.calibrated;
            state_next.enable_flag = !(oc_tick || ov_tick || uv_hit || wdt_tick) &&
                                     item.operator_enable && item.calibrated;
         end
         dfp_pkg::ACTION_FEED: begin
            state_next.wdt_count = '0;
            state_next.wdt_flag  = 1'b0;
         end
         dfp_pkg::ACTION_CLEAR: begin
            state_next.oc_latch  = 1'b0;
            state_next.ov_latch  = 1'b0;
            state_next.wdt_count = '0;
            state_next.wdt_flag  = 1'b0;
         end
         default: begin
            state_next = state_cur;
         end
      endcase
   end

endmodule

### rtl/drive_fault_protection_top.sv
// a result is valid in the cycle after its transaction is accepted
// throughput: one transaction per cycle while the result side keeps ready high
// the protection state registers double as the result register, so a stalled
// result blocks the next request until it is taken
// reset (synchronous, active high) clears all flags and the watchdog count and
// loads the threshold registers with their defaults
module drive_fault_protection_top (
   input  logic                              clock,
   input  logic                              reset,
   dfp_req_if.sink                           req_chan,
   dfp_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_en,
   input  logic [dfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dfp_pkg::COUNT_W-1:0]       csr_write_data
);

`include "assert_macros.svh"

   dfp_pkg::dfp_cfg_type   cfg_ff;
   dfp_pkg::dfp_state_type state_ff;
   dfp_pkg::dfp_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   req_accept;

   // the result slot is free when empty or being drained this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // next state for the accepted transaction: compares and the counter step
   dfp_fault_core u_core (
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .item       (req_chan.payload),
      .state_next (state_in)
   );

   // threshold registers, to be written only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overcurrent_level  <= dfp_pkg::OVERCURRENT_RESET;
         cfg_ff.overvoltage_level  <= dfp_pkg::OVERVOLTAGE_RESET;
         cfg_ff.undervoltage_level <= dfp_pkg::UNDERVOLTAGE_RESET;
         cfg_ff.watchdog_limit     <= dfp_pkg::WATCHDOG_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dfp_pkg::CSR_OVERCURRENT_LEVEL: begin
               cfg_ff.overcurrent_level <= csr_write_data[dfp_pkg::LEVEL_W-1:0];
            end
            dfp_pkg::CSR_OVERVOLTAGE_LEVEL: begin
               cfg_ff.overvoltage_level <= csr_write_data[dfp_pkg::LEVEL_W-1:0];
            end
            dfp_pkg::CSR_UNDERVOLTAGE_LEVEL: begin
               cfg_ff.undervoltage_level <= csr_write_data[dfp_pkg::LEVEL_W-1:0];
            end
            dfp_pkg::CSR_WATCHDOG_LIMIT: begin
               cfg_ff.watchdog_limit <= csr_write_data;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // protection state moves only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // every result reports the state as left by its transaction; gate_ok is
   // the fresh decision on a tick and the held enable otherwise, which is
   // the stored enable flag in both cases
   assign rsp_chan.valid                       = rsp_valid_ff;
   assign rsp_chan.payload.gate_ok             = state_ff.enable_flag;
   assign rsp_chan.payload.overcurrent_tripped = state_ff.oc_latch;
   assign rsp_chan.payload.overvoltage_tripped = state_ff.ov_latch;
   assign rsp_chan.payload.undervoltage_now    = state_ff.uv_flag;
   assign rsp_chan.payload.watchdog_expired    = state_ff.wdt_flag;
   assign rsp_chan.payload.calibration_flag    = state_ff.calib_flag;
   assign rsp_chan.payload.enabled_flag        = state_ff.enable_flag;

   // a latched overcurrent only releases on an accepted clear
   `DFP_ASSERT_NEXT(a_oc_holds, clock, reset, state_ff.oc_latch && !(req_accept && req_chan.payload.action == dfp_pkg::ACTION_CLEAR), state_ff.oc_latch, "overcurrent latch released without clear")

   // the watchdog counter saturates instead of wrapping
   `DFP_ASSERT_NEXT(a_count_sat, clock, reset, state_ff.wdt_count == dfp_pkg::COUNT_MAX && !(req_accept && (req_chan.payload.action == dfp_pkg::ACTION_FEED || req_chan.payload.action == dfp_pkg::ACTION_CLEAR)), state_ff.wdt_count == dfp_pkg::COUNT_MAX, "watchdog count wrapped")

   // gate enable never stands with a fault present
   `DFP_ASSERT(a_gate_safe, clock, reset, !(state_ff.enable_flag && (state_ff.oc_latch || state_ff.ov_latch || state_ff.uv_flag || state_ff.wdt_flag)), "gate enabled while a fault is set")

   // every accepted transaction leaves a result behind
   `DFP_ASSERT_NEXT(a_rsp_follows, clock, reset, req_accept, rsp_chan.valid, "accepted transaction produced no result")

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TIMEOUT_CYCLES  = 400_000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int PRESSURE_ITEMS  = 40;
   localparam int LONG_HOLD       = 60;
   localparam int CSR_DATA_W      = dfp_pkg::COUNT_W;

   // the block treats the spare action code as a no-op
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_en;
   logic [dfp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [dfp_pkg::COUNT_W-1:0]     csr_write_data;

   dfp_req_if req_chan ();
   dfp_rsp_if rsp_chan ();

   drive_fault_protection_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // shadow copy of the protection state and the threshold registers
   dfp_pkg::dfp_state_type prot;
   dfp_pkg::dfp_cfg_type   limits;

   // flags predicted for accepted requests, oldest first
   dfp_pkg::dfp_rsp_type flags_due[$];

   int mismatch_count = 0;
   int send_gap_pct   = 0;
   int rsp_stall_pct  = 0;
   int rsp_hold_left  = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // phase current magnitude above the overcurrent level
   // the most negative sample has magnitude 32768, so it needs 17 bits
   function automatic logic over_level(input logic [15:0] sample);
      logic [16:0] mag;
      mag = sample[15] ? 17'h10000 - {1'b0, sample} : {1'b0, sample};
      return mag > {1'b0, limits.overcurrent_level};
   endfunction

   // applies one request to the shadow state and returns the flags it yields
   function automatic dfp_pkg::dfp_rsp_type protect_step(input dfp_pkg::dfp_req_type item);
      dfp_pkg::dfp_rsp_type flags;
      logic                 gate;
      gate = prot.enable_flag;
      case (item.action)
         dfp_pkg::ACTION_TICK: begin
            if (over_level(item.current_a) || over_level(item.current_b) ||
                over_level(item.current_c))
               prot.oc_latch = 1'b1;
            if (item.link_voltage > limits.overvoltage_level)
               prot.ov_latch = 1'b1;
            prot.uv_flag = item.link_voltage < limits.undervoltage_level;
            // watchdog count saturates instead of wrapping
            if (prot.wdt_count != dfp_pkg::COUNT_MAX)
               prot.wdt_count = prot.wdt_count + 1'b1;
            if (prot.wdt_count > limits.watchdog_limit)
               prot.wdt_flag = 1'b1;
            prot.calib_flag = item.calibrated;
            gate = !(prot.oc_latch || prot.ov_latch || prot.uv_flag || prot.wdt_flag)
                   && item.operator_enable && item.calibrated;
            prot.enable_flag = gate;
         end
         dfp_pkg::ACTION_FEED: begin
            prot.wdt_count = '0;
            prot.wdt_flag  = 1'b0;
         end
         dfp_pkg::ACTION_CLEAR: begin
            prot.oc_latch  = 1'b0;
            prot.ov_latch  = 1'b0;
            prot.wdt_count = '0;
            prot.wdt_flag  = 1'b0;
         end
         default: begin
            // spare code: state untouched, held enable comes back
         end
      endcase
      flags.gate_ok             = gate;
      flags.overcurrent_tripped = prot.oc_latch;
      flags.overvoltage_tripped = prot.ov_latch;
      flags.undervoltage_now    = prot.uv_flag;
      flags.watchdog_expired    = prot.wdt_flag;
      flags.calibration_flag    = prot.calib_flag;
      flags.enabled_flag        = prot.enable_flag;
      return flags;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic int clamp(input int value, input int lo, input int hi);
      return (value < lo) ? lo : (value > hi) ? hi : value;
   endfunction

   function automatic dfp_pkg::dfp_req_type make_tick(input int a, input int b, input int c,
                                                      input int volts, input logic user,
                                                      input logic cal);
      dfp_pkg::dfp_req_type item;
      item.action          = dfp_pkg::ACTION_TICK;
      item.current_a       = a[15:0];
      item.current_b       = b[15:0];
      item.current_c       = c[15:0];
      item.link_voltage    = volts[15:0];
      item.operator_enable = user;
      item.calibrated      = cal;
      return item;
   endfunction

   // non-tick request: sample fields are don't-care, so fill them with noise
   function automatic dfp_pkg::dfp_req_type make_command(input logic [1:0] action);
      dfp_pkg::dfp_req_type item;
      item = make_tick(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
      item.action = action;
      return item;
   endfunction

   // current sample, mostly well below the trip level, sometimes around it or at full scale
   function automatic int pick_current(input logic stress);
      int level;
      int value;
      level = int'(limits.overcurrent_level);
      if (!stress)
         value = $urandom_range(level / 2);
      else
         case ($urandom_range(4))
            0: value = $urandom;
            1: value = level - 2 + $urandom_range(4);
            2: value = -(level - 2 + $urandom_range(4));
            3: value = $urandom_range(1) ? 32767 : -32768;
            default: value = $urandom_range(level / 2);
         endcase
      if (!stress && $urandom_range(1))
         value = -value;
      return clamp(value, -32768, 32767);
   endfunction

   // link voltage, mostly inside the window, sometimes on its edges, at the rails or anywhere
   function automatic int pick_voltage(input logic stress);
      int ov;
      int uv;
      int value;
      ov = int'(limits.overvoltage_level);
      uv = int'(limits.undervoltage_level);
      if (!stress && uv <= ov)
         value = $urandom_range(ov, uv);
      else
         case ($urandom_range(4))
            0: value = ov - 2 + $urandom_range(4);
            1: value = uv - 2 + $urandom_range(4);
            2: value = $urandom_range(1) ? 65535 : 0;
            default: value = $urandom_range(65535);
         endcase
      return clamp(value, 0, 65535);
   endfunction

   // mostly clean ticks, a fifth of them pushed toward the trip levels, plus feed, clear and spare-code commands
   function automatic dfp_pkg::dfp_req_type random_item();
      int   pick;
      logic stress;
      pick   = $urandom_range(99);
      stress = ($urandom_range(99) < 20);
      if (pick < 80)
         return make_tick(pick_current(stress), pick_current(stress),
                          pick_current(stress), pick_voltage(stress),
                          $urandom_range(9) != 0, $urandom_range(9) != 0);
      else if (pick < 89)
         return make_command(dfp_pkg::ACTION_FEED);
      else if (pick < 96)
         return make_command(dfp_pkg::ACTION_CLEAR);
      else
         return make_command(ACTION_UNUSED);
   endfunction

   function automatic dfp_pkg::dfp_cfg_type random_limits();
      dfp_pkg::dfp_cfg_type cfg;
      cfg.overcurrent_level  = 16'($urandom_range(32768, 500));
      cfg.overvoltage_level  = 16'($urandom_range(65535, 20000));
      cfg.undervoltage_level = 16'($urandom_range(20000, 0));
      cfg.watchdog_limit     = 24'($urandom_range(40, 2));
      return cfg;
   endfunction

   task automatic set_idle_mode(input idle_mode_type mode);
      send_gap_pct  = (mode == IDLE_SENDER)   ? 75 : (mode == IDLE_BOTH) ? 34 : 0;
      rsp_stall_pct = (mode == IDLE_RECEIVER) ? 75 : (mode == IDLE_BOTH) ? 34 : 0;
   endtask

   // offers one request, idling first at random, and records its flags
   // valid stays high on return so back-to-back requests need no toggle
   task automatic send_request(input dfp_pkg::dfp_req_type item);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      flags_due.push_back(protect_step(item));
   endtask

   // stops offering, waits for every pending result, then lets the block settle
   task automatic wait_for_idle();
      req_chan.valid <= 1'b0;
      while (flags_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write enable is left high; the caller lowers it after the last write
   task automatic write_register(input logic [dfp_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [dfp_pkg::COUNT_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // threshold changes only happen with the block drained
   task automatic load_limits(input dfp_pkg::dfp_cfg_type cfg);
      wait_for_idle();
      write_register(dfp_pkg::CSR_OVERCURRENT_LEVEL,  CSR_DATA_W'(cfg.overcurrent_level));
      write_register(dfp_pkg::CSR_OVERVOLTAGE_LEVEL,  CSR_DATA_W'(cfg.overvoltage_level));
      write_register(dfp_pkg::CSR_UNDERVOLTAGE_LEVEL, CSR_DATA_W'(cfg.undervoltage_level));
      write_register(dfp_pkg::CSR_WATCHDOG_LIMIT,     cfg.watchdog_limit);
      csr_write_en <= 1'b0;
      limits = cfg;
   endtask

   // ---------------------------------------------------------------------
   // result side: ready pattern and checking
   // ---------------------------------------------------------------------

   // a long hold request wins over the random stall pattern
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic check_flag(input string field, input logic expected, input logic actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0b, got %0b", field, expected, actual);
         mismatch_count++;
      end
   endtask

   // every result transaction is matched against the oldest prediction
   always @(posedge clock) begin : check_results
      dfp_pkg::dfp_rsp_type want;
      dfp_pkg::dfp_rsp_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = rsp_chan.payload;
         if (flags_due.size() == 0) begin
            $error("result transaction with no request pending");
            mismatch_count++;
         end else begin
            want = flags_due.pop_front();
            check_flag("gate_ok", want.gate_ok, got.gate_ok);
            check_flag("overcurrent_tripped", want.overcurrent_tripped,
                       got.overcurrent_tripped);
            check_flag("overvoltage_tripped", want.overvoltage_tripped,
                       got.overvoltage_tripped);
            check_flag("undervoltage_now", want.undervoltage_now, got.undervoltage_now);
            check_flag("watchdog_expired", want.watchdog_expired, got.watchdog_expired);
            check_flag("calibration_flag", want.calibration_flag, got.calibration_flag);
            check_flag("enabled_flag", want.enabled_flag, got.enabled_flag);
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // threshold edges, every action, enable gating and the watchdog extremes
   task automatic test_edges();
      set_idle_mode(IDLE_NONE);
      // defaults: clean tick drives the gates
      send_request(make_tick(0, 0, 0, 1000, 1'b1, 1'b1));
      // most negative current sits exactly on the default level, no trip
      // full-scale voltage equals the default limit, no trip either
      send_request(make_tick(-32768, 32767, -32767, 65535, 1'b1, 1'b1));
      send_request(make_command(ACTION_UNUSED));
      // gate needs both operator enable and calibration
      send_request(make_tick(0, 0, 0, 500, 1'b0, 1'b1));
      send_request(make_tick(0, 0, 0, 500, 1'b1, 1'b0));
      send_request(make_command(dfp_pkg::ACTION_FEED));
      send_request(make_command(dfp_pkg::ACTION_CLEAR));

      // overcurrent and overvoltage one below the defaults, undervoltage at full scale, zero watchdog limit
      load_limits('{16'd32767, 16'd65534, 16'd65535, 24'd0});
      send_request(make_tick(-32768, 0, 0, 65535, 1'b1, 1'b1));
      send_request(make_command(dfp_pkg::ACTION_FEED));
      // latched overcurrent survives a feed
      send_request(make_tick(0, 32767, 0, 65534, 1'b1, 1'b1));
      send_request(make_command(ACTION_UNUSED));
      send_request(make_command(dfp_pkg::ACTION_CLEAR));
      send_request(make_tick(0, 0, 32767, 0, 1'b1, 1'b1));

      // zero levels, watchdog limit at its top so it can never expire
      load_limits('{16'd0, 16'd0, 16'd0, dfp_pkg::COUNT_MAX});
      send_request(make_command(dfp_pkg::ACTION_CLEAR));
      send_request(make_tick(0, 0, 0, 0, 1'b1, 1'b1));
      send_request(make_tick(1, 0, 0, 0, 1'b1, 1'b1));
      send_request(make_tick(0, -1, 0, 1, 1'b1, 1'b1));
      send_request(make_command(dfp_pkg::ACTION_CLEAR));
      send_request(make_tick(0, 0, -1, 0, 1'b1, 1'b1));
      send_request(make_command(dfp_pkg::ACTION_FEED));
   endtask

   // result side held off long enough that the block stalls its input,
   // then the sender waits for the block to drain before carrying on
   task automatic test_backpressure();
      load_limits('{16'd20000, 16'd60000, 16'd100, 24'd25});
      set_idle_mode(IDLE_NONE);
      rsp_hold_left = LONG_HOLD;
      repeat (PRESSURE_ITEMS) send_request(random_item());
      wait_for_idle();
      set_idle_mode(IDLE_BOTH);
      repeat (PRESSURE_ITEMS) send_request(random_item());
   endtask

   // random traffic over several threshold settings and idle patterns
   task automatic test_random_phases();
      dfp_pkg::dfp_cfg_type cfg;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: cfg = '{dfp_pkg::OVERCURRENT_RESET, dfp_pkg::OVERVOLTAGE_RESET,
                       dfp_pkg::UNDERVOLTAGE_RESET, dfp_pkg::WATCHDOG_RESET};
            // every check can trip: zero levels, undervoltage at full scale
            1: cfg = '{16'd0, 16'd0, 16'hFFFF, 24'd0};
            // nothing can trip on current, watchdog never expires
            4: cfg = '{16'hFFFF, 16'hFFFE, 16'd1, dfp_pkg::COUNT_MAX};
            default: cfg = random_limits();
         endcase
         load_limits(cfg);
         set_idle_mode(idle_mode_type'(phase % 4));
         repeat (ITEMS_PER_PHASE) send_request(random_item());
      end
   endtask

   // ---------------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------------

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_en     <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      prot   = '0;
      limits = '{dfp_pkg::OVERCURRENT_RESET, dfp_pkg::OVERVOLTAGE_RESET,
                 dfp_pkg::UNDERVOLTAGE_RESET, dfp_pkg::WATCHDOG_RESET};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_edges();
      test_backpressure();
      test_random_phases();

      // drain, then watch for stray results
      set_idle_mode(IDLE_NONE);
      wait_for_idle();
      if (mismatch_count == 0)
         $display("** drive_fault_protection_top: PASSED **");
      else
         $display("** drive_fault_protection_top: FAILED **");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("** drive_fault_protection_top: FAILED **");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/dfp_pkg.sv
rtl/dfp_req_if.sv
rtl/dfp_rsp_if.sv
rtl/dfp_fault_core.sv
rtl/drive_fault_protection_top.sv
tb/tb_top.sv
